[rtl/core/glce_pkg.sv]
// Package for the grouped letter code encoder.
// Holds character constants, code and result types shared by all modules.
// No dependencies.
`default_nettype none

package glce_pkg;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_G = 8'h67;
    localparam logic [7:0] CHAR_O = 8'h6F;
    localparam logic [7:0] CHAR_Z = 8'h7A;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned HELD_W    = BYTE_BITS - 1;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned VALID_W   = 4;
    localparam int unsigned CODE_W    = 6;
    localparam int unsigned PACK_W    = HELD_W + CODE_W;

    typedef struct packed {
        logic                is_letter;
        logic [CODE_W-1:0]   bits;
        logic [COUNT_W-1:0]  len;
    } code_t;

    typedef struct packed {
        logic                 emit;
        logic [7:0]           out_byte;
        logic [VALID_W-1:0]   valid_bits;
        logic                 end_of_message;
    } pack_out_t;

endpackage

`default_nettype wire

[rtl/core/glce_letter_coder.sv]
// Letter coder: maps one character byte to its group and in-group code.
// Depends on glce_pkg.
`default_nettype none

module glce_letter_coder (
    input  wire logic [7:0]     char_code,
    output glce_pkg::code_t     code
);
    import glce_pkg::*;

    logic [1:0] group;
    logic [7:0] base;
    logic [7:0] offset;

    always_comb
    begin
        priority if (char_code < CHAR_C)
        begin
            group = 2'd0;
            base  = CHAR_A;
        end
        else if (char_code < CHAR_G)
        begin
            group = 2'd1;
            base  = CHAR_C;
        end
        else if (char_code < CHAR_O)
        begin
            group = 2'd2;
            base  = CHAR_G;
        end
        else
        begin
            group = 2'd3;
            base  = CHAR_O;
        end
    end

    assign offset         = char_code - base;
    assign code.is_letter = (char_code >= CHAR_A) && (char_code <= CHAR_Z);
    assign code.bits      = {offset[3:0], group};
    assign code.len       = {1'b0, group} + 3'd3;

endmodule

`default_nettype wire

[rtl/core/glce_bit_packer.sv]
// Bit packer: holds partial byte state and packs code bits LSB first.
// Emits full bytes and end-of-message flushes. Depends on glce_pkg.
`default_nettype none

module glce_bit_packer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire glce_pkg::code_t code,
    output glce_pkg::pack_out_t  pack_out
);
    import glce_pkg::*;

    logic [HELD_W-1:0]  held_bits_reg;
    logic [HELD_W-1:0]  held_bits_next;
    logic [COUNT_W-1:0] held_count_reg;
    logic [COUNT_W-1:0] held_count_next;

    logic [PACK_W-1:0]  shifted;
    logic [PACK_W-1:0]  packed_bits;
    logic [VALID_W-1:0] total;
    logic               full;

    assign shifted     = {{(PACK_W-CODE_W){1'b0}}, code.bits} << held_count_reg;
    assign packed_bits = {{(PACK_W-HELD_W){1'b0}}, held_bits_reg} | shifted;
    assign total       = {1'b0, held_count_reg} + {1'b0, code.len};
    assign full        = total >= VALID_W'(BYTE_BITS);

    always_comb
    begin
        if (!code.is_letter)
        begin
            pack_out.emit           = 1'b1;
            pack_out.out_byte       = {1'b0, held_bits_reg};
            pack_out.valid_bits     = {1'b0, held_count_reg};
            pack_out.end_of_message = 1'b1;
            held_bits_next          = '0;
            held_count_next         = '0;
        end
        else if (full)
        begin
            pack_out.emit           = 1'b1;
            pack_out.out_byte       = packed_bits[BYTE_BITS-1:0];
            pack_out.valid_bits     = VALID_W'(BYTE_BITS);
            pack_out.end_of_message = 1'b0;
            held_bits_next          = {{(BYTE_BITS+HELD_W-PACK_W){1'b0}},
                                       packed_bits[PACK_W-1:BYTE_BITS]};
            held_count_next         = total[COUNT_W-1:0];
        end
        else
        begin
            pack_out.emit           = 1'b0;
            pack_out.out_byte       = packed_bits[BYTE_BITS-1:0];
            pack_out.valid_bits     = total;
            pack_out.end_of_message = 1'b0;
            held_bits_next          = packed_bits[HELD_W-1:0];
            held_count_next         = total[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits_reg  <= '0;
            held_count_reg <= '0;
        end
        else if (step)
        begin
            held_bits_reg  <= held_bits_next;
            held_count_reg <= held_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        step && !code.is_letter |=> held_bits_reg == '0 && held_count_reg == '0)
        else $error("held state not cleared after flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (held_bits_reg >> held_count_reg) == '0)
        else $error("held bits set above held count");

    assert property (@(posedge clk) disable iff (!rst_n)
        pack_out.emit && code.is_letter |-> pack_out.valid_bits == VALID_W'(BYTE_BITS)
            && !pack_out.end_of_message)
        else $error("full byte emitted with wrong valid bits or end mark");

endmodule

`default_nettype wire

[rtl/core/grouped_letter_code_encoder.sv]
// Grouped letter code encoder, top level. Depends on glce_pkg, glce_letter_coder
// and glce_bit_packer.
// Path: input register, then result register; an output stall holds the item in the first.
// Throughput: one item per cycle (one coder and packer pass each) unless output stalls.
// Reset: rst_n asynchronous active low clears both valid flags and the held bits/count.
`default_nettype none

module grouped_letter_code_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_ready,
    input  wire logic [7:0]  char_code,
    output logic             code_valid,
    input  wire logic        code_ready,
    output logic [7:0]       out_byte,
    output logic [3:0]       valid_bits,
    output logic             end_of_message
);
    import glce_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_advance;

    logic       out_valid_reg;
    logic       out_valid_next;
    pack_out_t  out_result_reg;

    code_t      code;
    pack_out_t  pack_out;

    glce_letter_coder u_coder (
        .char_code (s1_char_reg),
        .code      (code)
    );

    glce_bit_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_advance),
        .code     (code),
        .pack_out (pack_out)
    );

    assign s1_advance = s1_valid_reg && (!pack_out.emit || !out_valid_reg || code_ready);
    assign char_ready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        if (char_valid && char_ready)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_advance && pack_out.emit)
            out_valid_next = 1'b1;
        else if (code_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            s1_char_reg <= char_code;
        if (s1_advance && pack_out.emit)
            out_result_reg <= pack_out;
    end

    assign code_valid     = out_valid_reg;
    assign out_byte       = out_result_reg.out_byte;
    assign valid_bits     = out_result_reg.valid_bits;
    assign end_of_message = out_result_reg.end_of_message;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_char_reg))
        else $error("pending item lost in input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && pack_out.emit |=> out_valid_reg)
        else $error("emitted result not registered");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !code_ready |-> !(s1_advance && pack_out.emit))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[sim/grouped_letter_code_encoder_tb.sv]
// Self-checking testbench for grouped_letter_code_encoder: directed and random character
// streams, random gaps and stalls on both handshakes, results checked against a local encoder.
// Depends on glce_pkg and the encoder RTL.

module grouped_letter_code_encoder_tb;

    import glce_pkg::*;

    typedef struct packed {
        logic [7:0]          data;
        logic [VALID_W-1:0]  nbits;
        logic                eom;
    } coded_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  char_code = 8'h00;
    logic        code_valid;
    logic        code_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [3:0]  valid_bits;
    logic        end_of_message;

    logic [7:0]          char_stream[$];
    coded_byte_t         coded_bytes[$];
    logic [HELD_W-1:0]   acc_bits = '0;
    logic [COUNT_W-1:0]  acc_count = '0;
    int unsigned         stream_len = 0;
    int unsigned         chars_taken = 0;
    int unsigned         fail_count = 0;
    logic                char_fire_q = 1'b0;
    int unsigned         send_gap = 0;
    int unsigned         recv_stall = 0;
    int unsigned         hold_off_left = 0;
    logic                hold_off_done = 1'b0;

    grouped_letter_code_encoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_code      (char_code),
        .code_valid     (code_valid),
        .code_ready     (code_ready),
        .out_byte       (out_byte),
        .valid_bits     (valid_bits),
        .end_of_message (end_of_message)
    );

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        return CHAR_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_terminator();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c >= CHAR_A && c <= CHAR_Z)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void encode_char(input logic [7:0] ch, output bit emits,
                                        output coded_byte_t res);
        logic [1:0]         grp;
        logic [3:0]         idx;
        logic [PACK_W-1:0]  acc;
        int unsigned        cnt;
        emits = 1'b0;
        res = '0;
        if (ch < CHAR_A || ch > CHAR_Z)
        begin
            emits = 1'b1;
            res.data = {1'b0, acc_bits};
            res.nbits = VALID_W'(acc_count);
            res.eom = 1'b1;
            acc_bits = '0;
            acc_count = '0;
        end
        else
        begin
            if (ch < CHAR_C)
            begin
                grp = 2'd0;
                idx = 4'(ch - CHAR_A);
            end
            else if (ch < CHAR_G)
            begin
                grp = 2'd1;
                idx = 4'(ch - CHAR_C);
            end
            else if (ch < CHAR_O)
            begin
                grp = 2'd2;
                idx = 4'(ch - CHAR_G);
            end
            else
            begin
                grp = 2'd3;
                idx = 4'(ch - CHAR_O);
            end
            cnt = acc_count;
            acc = PACK_W'(acc_bits) | (PACK_W'(grp) << cnt);
            cnt = cnt + 2;
            acc = acc | (PACK_W'(idx) << cnt);
            cnt = cnt + grp + 1;
            if (cnt >= BYTE_BITS)
            begin
                emits = 1'b1;
                res.data = acc[7:0];
                res.nbits = VALID_W'(BYTE_BITS);
                res.eom = 1'b0;
                acc_bits = HELD_W'(acc >> BYTE_BITS);
                acc_count = COUNT_W'(cnt - BYTE_BITS);
            end
            else
            begin
                acc_bits = acc[HELD_W-1:0];
                acc_count = COUNT_W'(cnt);
            end
        end
    endfunction

    // Sender: hold the item until taken, then idle or present the next one.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(char_valid && !char_fire_q))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    char_valid <= 1'b0;
                end
                else if (char_stream.size() > 0)
                begin
                    char_code <= char_stream.pop_front();
                    char_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off once the stream is under way.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_left > 0)
            begin
                hold_off_left <= hold_off_left - 1;
                code_ready <= 1'b0;
            end
            else if (!hold_off_done && chars_taken >= 150)
            begin
                hold_off_done <= 1'b1;
                hold_off_left <= 80;
                code_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                code_ready <= 1'b0;
            end
            else
            begin
                code_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        bit           emits;
        coded_byte_t  res;
        coded_byte_t  exp_res;
        char_fire_q <= char_valid && char_ready && rst_n;
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                encode_char(char_code, emits, res);
                if (emits)
                    coded_bytes.push_back(res);
                chars_taken <= chars_taken + 1;
            end
            if (code_valid && code_ready)
            begin
                if (coded_bytes.size() == 0)
                begin
                    $error("unexpected item: out_byte %h valid_bits %0d end_of_message %b",
                           out_byte, valid_bits, end_of_message);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_res = coded_bytes.pop_front();
                    if (out_byte !== exp_res.data)
                    begin
                        $error("out_byte: expected %h, actual %h", exp_res.data, out_byte);
                        fail_count = fail_count + 1;
                    end
                    if (valid_bits !== exp_res.nbits)
                    begin
                        $error("valid_bits: expected %0d, actual %0d",
                               exp_res.nbits, valid_bits);
                        fail_count = fail_count + 1;
                    end
                    if (end_of_message !== exp_res.eom)
                    begin
                        $error("end_of_message: expected %b, actual %b",
                               exp_res.eom, end_of_message);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned wlen;
        // empty flush, every group edge, terminators on both sides of the letter range
        char_stream = '{8'h00, CHAR_A, 8'h62, CHAR_C, 8'h66, CHAR_G, 8'h6E, CHAR_O, CHAR_Z,
                        8'h60, 8'h7B, 8'hFF, CHAR_A, CHAR_C, 8'h80, CHAR_Z, CHAR_Z, CHAR_Z,
                        8'h41, 8'h7F, 8'h0A};
        while (char_stream.size() < 425)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                wlen = $urandom_range(1, 12);
                repeat (wlen)
                    char_stream.push_back(rand_letter());
                char_stream.push_back(rand_terminator());
            end
            else
            begin
                char_stream.push_back(8'($urandom_range(0, 255)));
            end
        end
        stream_len = char_stream.size();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (chars_taken < stream_len)
            @(posedge clk);
        while (coded_bytes.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (coded_bytes.size() > 0)
            $error("%0d expected items never arrived", coded_bytes.size());
        if (fail_count == 0 && coded_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
